// File: rtl/mmgc_pkg.sv
package mmgc_pkg;

    typedef enum logic [2:0] {
        REQ_ROW_START = 3'd0,
        REQ_EDGE      = 3'd1,
        REQ_PRIORITY  = 3'd2,
        REQ_START     = 3'd3,
        REQ_READ      = 3'd4
    } t_req_type;

    typedef enum logic [1:0] {
        CFG_NUM_VERTICES = 2'd0,
        CFG_NUM_HASHES   = 2'd1,
        CFG_NUM_ROUNDS   = 2'd2
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int FIELD_W    = 11;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [10:0] vertex;
        logic [12:0] edge_slot;
        logic [13:0] row_start;
        logic [9:0]  neighbor;
        logic [1:0]  hash_index;
        logic [30:0] priority_req;
    } t_in_req;

    typedef struct packed {
        logic [10:0] color;
        logic [10:0] colored_count;
        logic        done_res;
    } t_out_res;

    typedef struct packed {
        logic load;
        logic start_init;
        logic clr_wr;
        logic walk_init;
        logic rd_row0;
        logic rd_row1;
        logic cap_hi;
        logic rd_pv;
        logic cap_pv;
        logic rd_edge;
        logic k_inc;
        logic rd_nb;
        logic cmp;
        logic assign_color;
        logic h_inc;
        logic v_next;
        logic finish;
        logic rd_req;
        logic out_read;
    } t_dp_cmd;

    typedef struct packed {
        logic vfree;
        logic edge_end;
        logic nb_skip;
        logic hit;
        logic last_hash;
        logic last_vert;
        logic last_round;
        logic clr_last;
        logic no_work;
        logic out_valid;
    } t_dp_status;

endpackage

// File: rtl/mmgc_ram.sv
module mmgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mmgc_ctrl.sv
module mmgc_ctrl
    import mmgc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_req_type,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_CLEAR  = 13'b0000000000010,
        S_VROW0  = 13'b0000000000100,
        S_VROW1  = 13'b0000000001000,
        S_VCHK   = 13'b0000000010000,
        S_HSTART = 13'b0000000100000,
        S_HPV    = 13'b0000001000000,
        S_EDGE   = 13'b0000010000000,
        S_ENB    = 13'b0000100000000,
        S_ECMP   = 13'b0001000000000,
        S_HEND   = 13'b0010000000000,
        S_FIN    = 13'b0100000000000,
        S_RD     = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_acc;

    assign o_in_stall = (r_state != S_IDLE) || (i_status.out_valid && i_out_stall);
    assign w_acc      = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_req_type)
                        REQ_START: begin
                            o_cmd.start_init = 1'b1;
                            n_state          = S_CLEAR;
                        end
                        REQ_READ: begin
                            o_cmd.rd_req = 1'b1;
                            n_state      = S_RD;
                        end
                        default: begin
                            o_cmd.load = 1'b1;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    o_cmd.walk_init = 1'b1;
                    n_state = i_status.no_work ? S_FIN : S_VROW0;
                end
            end
            S_VROW0: begin
                o_cmd.rd_row0 = 1'b1;
                n_state       = S_VROW1;
            end
            S_VROW1: begin
                o_cmd.rd_row1 = 1'b1;
                n_state       = S_VCHK;
            end
            S_VCHK: begin
                o_cmd.cap_hi = 1'b1;
                if (i_status.vfree) begin
                    n_state = S_HSTART;
                end else begin
                    o_cmd.v_next = 1'b1;
                    n_state = (i_status.last_vert && i_status.last_round) ? S_FIN : S_VROW0;
                end
            end
            S_HSTART: begin
                o_cmd.rd_pv = 1'b1;
                n_state     = S_HPV;
            end
            S_HPV: begin
                o_cmd.cap_pv = 1'b1;
                n_state      = S_EDGE;
            end
            S_EDGE: begin
                if (i_status.edge_end) begin
                    n_state = S_HEND;
                end else begin
                    o_cmd.rd_edge = 1'b1;
                    n_state       = S_ENB;
                end
            end
            S_ENB: begin
                // drop self-loops and foreign neighbors
                if (i_status.nb_skip) begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_EDGE;
                end else begin
                    o_cmd.rd_nb = 1'b1;
                    n_state     = S_ECMP;
                end
            end
            S_ECMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_EDGE;
            end
            S_HEND: begin
                if (i_status.hit || i_status.last_hash) begin
                    o_cmd.assign_color = i_status.hit;
                    o_cmd.v_next       = 1'b1;
                    n_state = (i_status.last_vert && i_status.last_round) ? S_FIN : S_VROW0;
                end else begin
                    o_cmd.h_inc = 1'b1;
                    n_state     = S_HSTART;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_RD: begin
                o_cmd.out_read = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/mmgc_dp.sv
module mmgc_dp
    import mmgc_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 8192,
    parameter int MAX_HASHES   = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_req               i_in_req,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_out_stall,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    output t_out_res              o_out_res
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int NW  = $clog2(MAX_VERTICES + 1);
    localparam int RW  = $clog2(MAX_VERTICES + 1);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int KW  = $clog2(MAX_EDGES + 1);
    localparam int HW  = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int HCW = $clog2(MAX_HASHES + 1);
    localparam int CW  = $clog2(2 * MAX_HASHES * 255 + 1);
    localparam int PW  = HW + VW;
    localparam int PD  = 2 ** PW;

    // configuration
    logic [10:0] r_cfg_nv;
    logic [2:0]  r_cfg_nh;
    logic [7:0]  r_cfg_nr;

    // control
    logic          r_started;
    logic [CW-1:0] r_last_unc;
    logic [NW-1:0] r_last_count;
    logic          r_out_valid;

    // walk state
    logic [NW-1:0]  r_nv;
    logic [HCW-1:0] r_nh;
    logic [7:0]     r_nr;
    logic [CW-1:0]  r_unc;
    logic [CW-1:0]  r_step;
    logic [CW-1:0]  r_base;
    logic [7:0]     r_round;
    logic [VW-1:0]  r_clr;
    logic [NW-1:0]  r_v;
    logic [HCW-1:0] r_h;
    logic [KW-1:0]  r_k;
    logic [KW-1:0]  r_lo;
    logic [KW-1:0]  r_hi;
    logic           r_vfree;
    logic [30:0]    r_pv;
    logic           r_max;
    logic           r_min;
    logic [NW-1:0]  r_count;
    logic           r_rd_oor;
    t_out_res       r_out;

    // memory ports
    logic          w_row_we;
    logic [RW-1:0] w_row_raddr;
    logic [13:0]   w_row_q;
    logic          w_edge_we;
    logic [9:0]    w_edge_q;
    logic          w_prio_we;
    logic [PW-1:0] w_prio_raddr;
    logic [30:0]   w_prio_q;
    logic          w_col_we;
    logic [VW-1:0] w_col_waddr;
    logic [CW-1:0] w_col_wdata;
    logic [VW-1:0] w_col_raddr;
    logic [CW-1:0] w_col_q;

    logic [HCW-1:0] w_nh;
    logic [KW-1:0]  w_row_clamp;
    logic           w_live;

    function automatic logic [KW-1:0] f_clamp(input logic [13:0] x);
        f_clamp = (int'(x) > MAX_EDGES) ? KW'(MAX_EDGES) : KW'(x);
    endfunction

    assign w_nh = (r_cfg_nh == 3'd0) ? HCW'(1) :
                  (int'(r_cfg_nh) > MAX_HASHES) ? HCW'(MAX_HASHES) : HCW'(r_cfg_nh);
    assign w_row_clamp = f_clamp(w_row_q);
    assign w_live      = (w_col_q >= r_base);

    assign w_row_we  = i_cmd.load && (i_in_req.req_type == REQ_ROW_START)
                       && (int'(i_in_req.vertex) <= MAX_VERTICES);
    assign w_edge_we = i_cmd.load && (i_in_req.req_type == REQ_EDGE)
                       && (int'(i_in_req.edge_slot) < MAX_EDGES);
    assign w_prio_we = i_cmd.load && (i_in_req.req_type == REQ_PRIORITY)
                       && (int'(i_in_req.vertex) < MAX_VERTICES)
                       && (int'(i_in_req.hash_index) < MAX_HASHES);

    assign w_row_raddr  = i_cmd.rd_row1 ? RW'(int'(r_v) + 1) : RW'(r_v);
    assign w_prio_raddr = i_cmd.rd_nb ? {HW'(r_h), VW'(w_edge_q)} : {HW'(r_h), VW'(r_v)};

    always_comb begin
        w_col_raddr = VW'(r_v);
        if (i_cmd.rd_req) begin
            w_col_raddr = VW'(i_in_req.vertex);
        end else if (i_cmd.rd_nb) begin
            w_col_raddr = VW'(w_edge_q);
        end
    end

    assign w_col_we    = i_cmd.clr_wr || i_cmd.assign_color;
    assign w_col_waddr = i_cmd.clr_wr ? r_clr : VW'(r_v);
    assign w_col_wdata = i_cmd.clr_wr ? r_unc
                       : CW'(int'(r_base) + 2 * int'(r_h) + int'(!r_max));

    mmgc_ram #(.WIDTH(14), .DEPTH(MAX_VERTICES + 1)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (RW'(i_in_req.vertex)),
        .i_wdata (i_in_req.row_start),
        .i_raddr (w_row_raddr),
        .o_rdata (w_row_q)
    );

    mmgc_ram #(.WIDTH(10), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_edge_we),
        .i_waddr (EW'(i_in_req.edge_slot)),
        .i_wdata (i_in_req.neighbor),
        .i_raddr (EW'(r_k)),
        .o_rdata (w_edge_q)
    );

    mmgc_ram #(.WIDTH(31), .DEPTH(PD)) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (w_prio_we),
        .i_waddr ({HW'(i_in_req.hash_index), VW'(i_in_req.vertex)}),
        .i_wdata (i_in_req.priority_req),
        .i_raddr (w_prio_raddr),
        .o_rdata (w_prio_q)
    );

    mmgc_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (w_col_we),
        .i_waddr (w_col_waddr),
        .i_wdata (w_col_wdata),
        .i_raddr (w_col_raddr),
        .o_rdata (w_col_q)
    );

    always_comb begin
        o_status            = '0;
        o_status.vfree      = r_vfree;
        o_status.edge_end   = (r_k >= r_hi);
        o_status.nb_skip    = (32'(w_edge_q) == 32'(r_v)) || (32'(w_edge_q) >= 32'(r_nv));
        o_status.hit        = r_max || r_min;
        o_status.last_hash  = (int'(r_h) + 1 == int'(r_nh));
        o_status.last_vert  = (int'(r_v) + 1 == int'(r_nv));
        o_status.last_round = (int'(r_round) + 1 == int'(r_nr));
        o_status.clr_last   = (int'(r_clr) == MAX_VERTICES - 1);
        o_status.no_work    = (r_nv == '0) || (r_nr == 8'd0);
        o_status.out_valid  = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_nv     <= 11'd0;
            r_cfg_nh     <= 3'd1;
            r_cfg_nr     <= 8'd1;
            r_started    <= 1'b0;
            r_last_unc   <= CW'(2);
            r_last_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NUM_VERTICES: r_cfg_nv <= i_cfg_wdata;
                    CFG_NUM_HASHES:   r_cfg_nh <= i_cfg_wdata[2:0];
                    CFG_NUM_ROUNDS:   r_cfg_nr <= i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.start_init) begin
                r_started  <= 1'b1;
                r_last_unc <= CW'(2 * int'(w_nh) * int'(r_cfg_nr));
            end
            if (i_cmd.finish) begin
                r_last_count <= r_count;
            end
            if (i_cmd.load || i_cmd.out_read || i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_init) begin
            r_nv   <= (int'(r_cfg_nv) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(r_cfg_nv);
            r_nh   <= w_nh;
            r_nr   <= r_cfg_nr;
            r_step <= CW'(2 * int'(w_nh));
            r_unc  <= CW'(2 * int'(w_nh) * int'(r_cfg_nr));
            r_clr  <= '0;
        end
        if (i_cmd.clr_wr) begin
            r_clr <= VW'(int'(r_clr) + 1);
        end
        if (i_cmd.walk_init) begin
            r_round <= 8'd0;
            r_base  <= '0;
            r_v     <= '0;
            r_count <= '0;
        end
        if (i_cmd.rd_row1) begin
            r_k     <= w_row_clamp;
            r_lo    <= w_row_clamp;
            r_vfree <= (w_col_q == r_unc);
        end
        if (i_cmd.cap_hi) begin
            r_hi <= w_row_clamp;
            r_h  <= '0;
        end
        if (i_cmd.cap_pv) begin
            r_pv  <= w_prio_q;
            r_max <= 1'b1;
            r_min <= 1'b1;
        end
        if (i_cmd.k_inc || i_cmd.cmp) begin
            r_k <= KW'(int'(r_k) + 1);
        end
        // only neighbors not colored in an earlier round take part
        if (i_cmd.cmp && w_live) begin
            if (r_pv <= w_prio_q) begin
                r_max <= 1'b0;
            end
            if (r_pv >= w_prio_q) begin
                r_min <= 1'b0;
            end
        end
        // rewind the edge walk for the next hash
        if (i_cmd.h_inc) begin
            r_h <= HCW'(int'(r_h) + 1);
            r_k <= r_lo;
        end
        if (i_cmd.assign_color) begin
            r_count <= NW'(int'(r_count) + 1);
        end
        if (i_cmd.v_next) begin
            if (o_status.last_vert) begin
                r_v     <= '0;
                r_round <= 8'(int'(r_round) + 1);
                r_base  <= CW'(int'(r_base) + int'(r_step));
            end else begin
                r_v <= NW'(int'(r_v) + 1);
            end
        end
        if (i_cmd.rd_req) begin
            r_rd_oor <= !r_started || (int'(i_in_req.vertex) >= MAX_VERTICES);
        end
        if (i_cmd.load) begin
            r_out <= '0;
        end else if (i_cmd.out_read) begin
            r_out.color         <= r_rd_oor ? FIELD_W'(r_last_unc) : FIELD_W'(w_col_q);
            r_out.colored_count <= FIELD_W'(r_last_count);
            r_out.done_res      <= 1'b1;
        end else if (i_cmd.finish) begin
            r_out.color         <= FIELD_W'(r_unc);
            r_out.colored_count <= FIELD_W'(r_count);
            r_out.done_res      <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

// File: rtl/multi_hash_max_min_graph_coloring_unit.sv
// Channel   Direction  Signals
// request   in         i_in_valid, o_in_stall, i_in_req
// result    out        o_out_valid, i_out_stall, o_out_res
// config    in         i_cfg_we, i_cfg_idx, i_cfg_wdata
//
// Loads answer from the idle state; a read adds the registered color memory read (S_RD).
// A start sweeps all MAX_VERTICES color words, then per round and vertex reads
// the row bounds and per hash tried reads the priority and walks the edges,
// bounded by the single read port of each memory; a final state ends the start.
// Reset is synchronous; before the first start every read returns color 2.
// The request side stalls while a start or read runs, or while a held result stalls.
module multi_hash_max_min_graph_coloring_unit
    import mmgc_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 8192,
    parameter int MAX_HASHES   = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_req               i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_res              o_out_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    mmgc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_in_req.req_type),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (w_cmd)
    );

    mmgc_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .MAX_HASHES   (MAX_HASHES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_res.done_res |->
            (o_out_res.color == '0) && (o_out_res.colored_count == '0))
        else $error("load result carries nonzero payload");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_req.req_type == REQ_START) |=> o_in_stall)
        else $error("start request did not hold off the request side");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.out_read, w_cmd.finish}))
        else $error("two result sources in one cycle");

endmodule

// File: bench/testbench.sv
module testbench;
    import mmgc_pkg::*;

    class mmgc_scoreboard;
        int unsigned nverts_reg, nhash_reg, nround_reg;
        int unsigned row_tab[1025];
        int unsigned edge_tab[8192];
        int unsigned prio_tab[4096];
        int unsigned col_cur[1024];
        int unsigned col_nxt[1024];
        int unsigned last_unc, last_cnt;
        t_out_res    pending[$];
        int          mismatches, checked, starts;

        function new();
            nverts_reg = 0;
            nhash_reg  = 1;
            nround_reg = 1;
            foreach (col_cur[v]) begin
                col_cur[v] = 2;
                col_nxt[v] = 2;
            end
            last_unc = 2;
            last_cnt = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, int unsigned data);
            case (idx)
                CFG_NUM_VERTICES: nverts_reg = data & 11'h7FF;
                CFG_NUM_HASHES:   nhash_reg  = data & 3'h7;
                CFG_NUM_ROUNDS:   nround_reg = data & 8'hFF;
                default: ;
            endcase
        endfunction

        // Rounds of max-min coloring; new colors show up only after each round.
        function int unsigned color_graph();
            int unsigned nv, nh, nr, unc, total, lo, hi, pv, pu, u;
            bit          is_max, is_min;
            nv = (nverts_reg > 1024) ? 1024 : nverts_reg;
            nh = (nhash_reg == 0) ? 1 : ((nhash_reg > 4) ? 4 : nhash_reg);
            nr = nround_reg;
            unc = 2 * nh * nr;
            total = 0;
            last_unc = unc;
            for (int v = 0; v < 1024; v++) begin
                col_cur[v] = unc;
                col_nxt[v] = unc;
            end
            for (int r = 0; r < nr; r++) begin
                for (int v = 0; v < nv; v++) begin
                    if (col_cur[v] != unc) continue;
                    lo = (row_tab[v] > 8192) ? 8192 : row_tab[v];
                    hi = (row_tab[v+1] > 8192) ? 8192 : row_tab[v+1];
                    for (int h = 0; h < nh; h++) begin
                        if (col_nxt[v] != unc) break;
                        is_max = 1;
                        is_min = 1;
                        pv = prio_tab[h*1024 + v];
                        for (int k = lo; k < hi; k++) begin
                            u = edge_tab[k];
                            if (u == v || u >= nv) continue;
                            if (col_cur[u] < unc) continue;
                            pu = prio_tab[h*1024 + u];
                            if (pv <= pu) is_max = 0;
                            if (pv >= pu) is_min = 0;
                        end
                        if (is_max) col_nxt[v] = r*2*nh + 2*h;
                        else if (is_min) col_nxt[v] = r*2*nh + 2*h + 1;
                    end
                end
                for (int v = 0; v < nv; v++) begin
                    if (col_cur[v] != col_nxt[v]) begin
                        total++;
                        col_cur[v] = col_nxt[v];
                    end
                end
            end
            last_cnt = total;
            return total;
        endfunction

        function void note_request(t_in_req r);
            t_out_res    res;
            int unsigned cnt;
            res = '0;
            case (r.req_type)
                REQ_ROW_START: if (r.vertex <= 1024) row_tab[r.vertex] = r.row_start;
                REQ_EDGE:      edge_tab[r.edge_slot] = r.neighbor;
                REQ_PRIORITY:  if (r.vertex < 1024)
                    prio_tab[r.hash_index*1024 + r.vertex] = r.priority_req;
                REQ_START: begin
                    cnt = color_graph();
                    starts++;
                    res.color = last_unc[10:0];
                    res.colored_count = cnt[10:0];
                    res.done_res = 1'b1;
                end
                REQ_READ: begin
                    res.color = (r.vertex < 1024) ? col_cur[r.vertex][10:0] : last_unc[10:0];
                    res.colored_count = last_cnt[10:0];
                    res.done_res = 1'b1;
                end
                default: ;
            endcase
            pending.push_back(res);
        endfunction

        function void check_result(t_out_res got);
            t_out_res want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result color=%0d count=%0d done=%0d",
                             got.color, got.colored_count, got.done_res);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d: exp color=%0d count=%0d done=%0d, got color=%0d count=%0d done=%0d",
                             checked, want.color, want.colored_count, want.done_res,
                             got.color, got.colored_count, got.done_res);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_req               in_req = '0;
    logic                  o_out_valid;
    logic                  out_stall = 1'b0;
    t_out_res              o_out_res;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    mmgc_scoreboard coloring_sb = new();
    int  n_sent = 0;
    int  n_phases = 0;
    bit  quiet = 0;
    bit  calm = 0;
    bit  hold_request = 0;
    int  hold_left = 0;
    int  burst_left = 0;
    int  calm_timer = 0;
    int  idle_cycles = 0;

    multi_hash_max_min_graph_coloring_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_res  (o_out_res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall)
            coloring_sb.check_result(o_out_res);
    end

    // Receiver: random stall bursts, calm stretches, and one long hold-off.
    always @(posedge i_clk) begin
        if (calm_timer == 0) begin
            calm = $urandom_range(0, 2) == 0;
            calm_timer = 256;
        end
        calm_timer--;
        if (hold_request) begin
            hold_left = 300;
            hold_request = 0;
        end
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            out_stall <= 1'b1;
        end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(1, 4) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 3000000) begin
            $display("ERROR: no progress for %0d cycles", idle_cycles);
            $display("multi_hash_max_min_graph_coloring_unit verification failed");
            $finish;
        end
    end

    function automatic t_in_req random_request(t_req_type kind);
        t_in_req r;
        r.req_type     = kind;
        r.vertex       = $urandom_range(0, 2047);
        r.edge_slot    = $urandom_range(0, 8191);
        r.row_start    = $urandom_range(0, 16383);
        r.neighbor     = $urandom_range(0, 1023);
        r.hash_index   = $urandom_range(0, 3);
        r.priority_req = $urandom;
        return r;
    endfunction

    task automatic send_request(input t_in_req r);
        if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge i_clk); while (o_in_stall);
        coloring_sb.note_request(r);
        n_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (coloring_sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data[CFG_DATA_W-1:0];
        @(posedge i_clk);
        coloring_sb.write_reg(idx, data);
    endtask

    task automatic shuffle(ref t_in_req q[$]);
        t_in_req tmp;
        int      j;
        for (int i = q.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = q[i];
            q[i] = q[j];
            q[j] = tmp;
        end
    endtask

    // Load a whole graph, color it, then read back its vertices (at most the first 64).
    task automatic color_phase(input int unsigned nv_reg, input int unsigned nh_reg,
                               input int unsigned nr_reg, input bit clamp_rows,
                               input bit close_prios, input bit long_hold);
        t_in_req     loads[$];
        t_in_req     reads[$];
        t_in_req     r;
        int unsigned nv, span, base, prio_sets, n_noise;
        wait_drained();
        write_reg(CFG_NUM_VERTICES, nv_reg);
        write_reg(CFG_NUM_HASHES, nh_reg);
        write_reg(CFG_NUM_ROUNDS, nr_reg);
        cfg_we <= 1'b0;
        n_phases++;
        nv = (nv_reg > 1024) ? 1024 : nv_reg;
        prio_sets = (nv > 64) ? 1 : 4;
        span = $urandom_range(0, (3*nv + 2 > 60) ? 60 : 3*nv + 2);
        base = clamp_rows ? 8192 - span : $urandom_range(0, 8191 - span);
        for (int v = 0; v <= nv; v++) begin
            r = random_request(REQ_ROW_START);
            r.vertex = v;
            r.row_start = base + $urandom_range(0, span);
            if (clamp_rows && $urandom_range(0, 3) == 0)
                r.row_start = $urandom_range(8192, 16383);
            loads.push_back(r);
        end
        for (int k = base; k < base + span; k++) begin
            r = random_request(REQ_EDGE);
            r.edge_slot = k;
            if (nv > 0 && $urandom_range(0, 4) != 0)
                r.neighbor = $urandom_range(0, nv - 1);
            else if (nv < 1024)
                r.neighbor = $urandom_range(nv, 1023);
            loads.push_back(r);
        end
        for (int v = 0; v < nv; v++) begin
            for (int h = 0; h < prio_sets; h++) begin
                r = random_request(REQ_PRIORITY);
                r.vertex = v;
                r.hash_index = h;
                if (close_prios)
                    r.priority_req = $urandom_range(0, 3);
                else if ($urandom_range(0, 15) == 0)
                    r.priority_req = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0;
                loads.push_back(r);
            end
        end
        n_noise = loads.size() / 8 + 2;
        for (int i = 0; i < n_noise; i++) begin
            case ($urandom_range(0, 3))
                0: r = random_request(t_req_type'($urandom_range(5, 7)));
                1: r = random_request(REQ_READ);
                2: begin
                    r = random_request(REQ_ROW_START);
                    r.vertex = $urandom_range(1025, 2047);
                end
                default: begin
                    r = random_request(REQ_PRIORITY);
                    r.vertex = $urandom_range(1024, 2047);
                end
            endcase
            loads.push_back(r);
        end
        shuffle(loads);
        if (long_hold) hold_request = 1;
        foreach (loads[i]) send_request(loads[i]);
        send_request(random_request(REQ_START));
        for (int v = 0; v < nv && v < 64; v++) begin
            r = random_request(REQ_READ);
            r.vertex = v;
            reads.push_back(r);
        end
        for (int i = 0; i < 3; i++) reads.push_back(random_request(REQ_READ));
        shuffle(reads);
        foreach (reads[i]) send_request(reads[i]);
    endtask

    initial begin
        t_in_req r;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Before any start: reads give the reset color, unknown codes write nothing and return an all-zero result.
        r = random_request(REQ_READ);
        r.vertex = 0;
        send_request(r);
        r.vertex = 11'h7FF;
        send_request(r);
        for (int c = 5; c <= 7; c++) send_request(random_request(t_req_type'(c)));

        color_phase(0, 1, 1, 0, 0, 0);
        color_phase(1, 1, 1, 0, 0, 0);
        color_phase(5, 4, 0, 0, 1, 0);
        color_phase(6, 0, 3, 1, 1, 0);
        color_phase(4, 7, 255, 0, 0, 0);
        color_phase(12, 4, 4, 0, 0, 1);

        while (n_sent < 1800) begin
            if (n_sent > 1500) quiet = 1;
            color_phase($urandom_range(2, 24), $urandom_range(0, 7),
                        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                    : $urandom_range(1, 6),
                        $urandom_range(0, 4) == 0, $urandom_range(0, 2) == 0, 0);
        end
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Ran %0d graph phases (%0d starts), %0d requests, %0d results checked.",
                 n_phases, coloring_sb.starts, n_sent, coloring_sb.checked);
        $display("Mismatches: %0d; results still expected: %0d.",
                 coloring_sb.mismatches, coloring_sb.pending.size());
        if (coloring_sb.mismatches == 0 && coloring_sb.pending.size() == 0)
            $display("multi_hash_max_min_graph_coloring_unit verification clean");
        else
            $display("multi_hash_max_min_graph_coloring_unit verification failed");
        $finish;
    end
endmodule
